// ===== sv/multi_axis_dda_step_generator_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the multi-axis DDA step generator
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MULTI_AXIS_DDA_STEP_GENERATOR_ASSERT_SVH
`define MULTI_AXIS_DDA_STEP_GENERATOR_ASSERT_SVH

// same-cycle implication
`define MADS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("step generator check failed");

// next-cycle implication
`define MADS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("step generator check failed");

`endif

// ===== sv/mads_pkg.sv =====
// ----------------------------------------------------------------------------
// mads_pkg
// Types and constants shared by the step generator and its axis lanes.
// ----------------------------------------------------------------------------
`default_nettype none

package mads_pkg;

    // request command codes
    typedef enum logic [2:0] {
        CMD_SET_POS     = 3'd0,
        CMD_LOAD_TARGET = 3'd1,
        CMD_START_MOVE  = 3'd2,
        CMD_TICK        = 3'd3,
        CMD_START_HOME  = 3'd4,
        CMD_ABORT       = 3'd5
    } cmd_t;

    // per-lane operation for the current cycle
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_SET_POS,
        OP_LOAD,
        OP_START_MOVE,
        OP_START_HOME,
        OP_MOVE_STEP,
        OP_HOME_STEP
    } lane_op_t;

    typedef struct packed {
        lane_op_t op;
        logic     home_sel;
    } lane_ctl_t;

    typedef struct packed {
        logic        step;
        logic        dir_nx;
        logic [31:0] pos_nx;
    } lane_stat_t;

    localparam int          OUT_AXES      = 5;   // axes visible on the mask outputs
    localparam int          HOMED_AXES    = 3;   // axes with endstops
    localparam logic [15:0] HOME_FAST_US  = 16'd50;
    localparam logic [15:0] HOME_MID_US   = 16'd100;
    localparam logic [31:0] HOME_INTERVALS = 32'h7FFF_FFFF;

endpackage

`default_nettype wire

// ===== sv/multi_axis_dda_step_generator.sv =====
// Each request waits in the request register; its results are registered.
// Throughput: one result per cycle unless the output stalls; a tick gives
// one result per sub-step (1 to 4), every other command one result, all
// axis lanes updating at once. A new request is taken in the cycle its
// predecessor issues its last result. Reset clears all axis state and
// flags, directions positive, homing multiplier one; no clearing pass.
// ----------------------------------------------------------------------------
// multi_axis_dda_step_generator
// Bresenham step generator: request register, per-axis lanes, move and
// homing sequencing, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_axis_dda_step_generator #(
    parameter int AXES = 5
) (
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [4:0]         cfg_data,
    // requests
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         cmd,
    input  logic [2:0]         axis,
    input  logic signed [31:0] axis_value,
    input  logic [30:0]        step_events,
    input  logic [2:0]         step_multiplier,
    input  logic [2:0]         min_endstop_hit,
    input  logic [2:0]         max_endstop_hit,
    input  logic               home_toward_max,
    input  logic [2:0]         home_axes,
    input  logic [15:0]        home_step_us,
    // results
    output logic               out_valid,
    input  logic               out_ready,
    output logic [4:0]         step_mask,
    output logic [4:0]         dir_mask,
    output logic               moving,
    output logic               homing_active,
    output logic               move_done,
    output logic signed [31:0] axis_position,
    output logic [16:0]        timer_period,
    output logic               last
);
    import mads_pkg::*;

    localparam int AXIS_W = $clog2(AXES);

    // configuration register
    logic [4:0] inv_reg;

    // request register
    logic        item_vld_reg;
    logic [2:0]  cmd_reg;
    logic [2:0]  axis_reg;
    logic [31:0] value_reg;
    logic [30:0] events_reg;
    logic [2:0]  smult_reg;
    logic [2:0]  min_reg;
    logic [2:0]  max_reg;
    logic        toward_max_reg;
    logic [2:0]  hmask_reg;
    logic [15:0] us_reg;
    logic [1:0]  sub_reg, sub_next;

    // global move state
    logic [30:0] intervals_reg, intervals_next;
    logic [31:0] left_reg,      left_next;
    logic        run_reg,       run_next;
    logic        home_reg,      home_next;
    logic [2:0]  hmult_reg,     hmult_next;
    logic [16:0] period_reg,    period_next;

    // result register
    logic        out_vld_reg;
    logic [4:0]  step_mask_reg;
    logic [4:0]  dir_mask_reg;
    logic        moving_reg;
    logic        homing_reg;
    logic        done_reg;
    logic [31:0] pos_out_reg;
    logic [16:0] period_out_reg;
    logic        last_reg;

    logic        take_in;
    logic        fire;
    logic        is_tick;
    logic        move_tick;
    logic        home_tick;
    logic [2:0]  sub_n;
    logic [2:0]  sub_cnt;
    logic [31:0] left_sub;
    logic        move_end;
    logic        move_last;
    logic        home_any;
    logic        home_last;
    logic        res_last;
    logic [31:0] err_start;
    logic        axis_ok;
    logic [31:0] pos_sel;
    logic [4:0]  step_all;
    logic [4:0]  dir_all;

    lane_ctl_t   ctl   [AXES];
    lane_stat_t  stat  [AXES];

    // configuration write
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_reg <= '0;
        end
        else if (cfg_valid)
        begin
            inv_reg <= cfg_data;
        end
    end

    // handshake
    assign fire     = item_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !item_vld_reg || (fire && res_last);
    assign take_in  = in_valid && in_ready;

    // request decode
    assign is_tick   = (cmd_reg == CMD_TICK);
    assign move_tick = is_tick && run_reg;
    assign home_tick = is_tick && !run_reg && home_reg;

    // sub-steps per moving tick
    always_comb
    begin
        if (smult_reg == 3'd0)
        begin
            sub_n = 3'd1;
        end
        else if (smult_reg > 3'd4)
        begin
            sub_n = 3'd4;
        end
        else
        begin
            sub_n = smult_reg;
        end
    end

    assign sub_cnt   = {1'b0, sub_reg} + 3'd1;
    assign left_sub  = left_reg - {29'd0, sub_n};
    assign move_end  = (left_sub == 32'd0) || left_sub[31];
    assign move_last = (sub_cnt == sub_n);
    assign home_last = !home_any || (sub_cnt == hmult_reg);

    always_comb
    begin
        if (move_tick)
        begin
            res_last = move_last;
        end
        else if (home_tick)
        begin
            res_last = home_last;
        end
        else
        begin
            res_last = 1'b1;
        end
    end

    assign err_start = 32'd0 - {2'd0, events_reg[30:1]};

    // axis lanes
    for (genvar i = 0; i < AXES; i++)
    begin : g_lane
        logic lane_min;
        logic lane_max;
        logic lane_sel;
        logic lane_homed;

        if (i < HOMED_AXES)
        begin : g_homed
            assign lane_min   = min_reg[i];
            assign lane_max   = max_reg[i];
            assign lane_sel   = hmask_reg[i];
            assign lane_homed = 1'b1;
        end
        else
        begin : g_free
            assign lane_min   = 1'b0;
            assign lane_max   = 1'b0;
            assign lane_sel   = 1'b0;
            assign lane_homed = 1'b0;
        end

        // lane operation for this cycle
        always_comb
        begin
            ctl[i].op       = OP_HOLD;
            ctl[i].home_sel = lane_sel;
            if (fire)
            begin
                unique case (cmd_t'(cmd_reg))
                    CMD_SET_POS:
                    begin
                        if (axis_reg == 3'(i))
                        begin
                            ctl[i].op = OP_SET_POS;
                        end
                    end
                    CMD_LOAD_TARGET:
                    begin
                        if (axis_reg == 3'(i))
                        begin
                            ctl[i].op = OP_LOAD;
                        end
                    end
                    CMD_START_MOVE:
                    begin
                        ctl[i].op = OP_START_MOVE;
                    end
                    CMD_TICK:
                    begin
                        if (run_reg)
                        begin
                            ctl[i].op = OP_MOVE_STEP;
                        end
                        else if (home_reg && lane_homed)
                        begin
                            ctl[i].op = OP_HOME_STEP;
                        end
                    end
                    CMD_START_HOME:
                    begin
                        ctl[i].op = OP_START_HOME;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        mads_axis u_axis (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl[i]),
            .value     (value_reg),
            .intervals (intervals_reg),
            .err_start (err_start),
            .min_hit   (lane_min),
            .max_hit   (lane_max),
            .home_dir  (toward_max_reg),
            .stat      (stat[i])
        );
    end

    // homing continues while any homed axis stepped
    always_comb
    begin
        home_any = 1'b0;
        for (int j = 0; j < HOMED_AXES; j++)
        begin
            home_any = home_any | stat[j].step;
        end
    end

    // mask outputs carry the first five axes
    for (genvar b = 0; b < OUT_AXES; b++)
    begin : g_mask
        if (b < AXES)
        begin : g_on
            assign step_all[b] = stat[b].step;
            assign dir_all[b]  = stat[b].dir_nx;
        end
        else
        begin : g_off
            assign step_all[b] = 1'b0;
            assign dir_all[b]  = 1'b0;
        end
    end

    // position readback after this result
    assign axis_ok = (32'(axis_reg) < AXES);
    assign pos_sel = axis_ok ? stat[axis_reg[AXIS_W-1:0]].pos_nx : 32'd0;

    // global state next values
    always_comb
    begin
        intervals_next = intervals_reg;
        left_next      = left_reg;
        run_next       = run_reg;
        home_next      = home_reg;
        hmult_next     = hmult_reg;
        period_next    = period_reg;
        if (fire)
        begin
            unique case (cmd_t'(cmd_reg))
                CMD_START_MOVE:
                begin
                    intervals_next = events_reg;
                    left_next      = {1'b0, events_reg};
                    run_next       = 1'b1;
                end
                CMD_TICK:
                begin
                    if (move_tick)
                    begin
                        if (move_last)
                        begin
                            left_next = left_sub;
                            if (move_end)
                            begin
                                run_next = 1'b0;
                            end
                        end
                    end
                    else if (home_tick)
                    begin
                        home_next = home_any;
                    end
                end
                CMD_START_HOME:
                begin
                    intervals_next = 31'd1;
                    left_next      = HOME_INTERVALS;
                    home_next      = 1'b1;
                    if (us_reg < HOME_FAST_US)
                    begin
                        hmult_next  = 3'd4;
                        period_next = {2'd0, us_reg[15:1]};
                    end
                    else if (us_reg < HOME_MID_US)
                    begin
                        hmult_next  = 3'd2;
                        period_next = {1'b0, us_reg};
                    end
                    else
                    begin
                        hmult_next  = 3'd1;
                        period_next = {us_reg, 1'b0};
                    end
                end
                CMD_ABORT:
                begin
                    run_next    = 1'b0;
                    home_next   = 1'b0;
                    hmult_next  = 3'd1;
                    period_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // sub-step counter
    always_comb
    begin
        sub_next = sub_reg;
        if (fire)
        begin
            sub_next = res_last ? 2'd0 : sub_cnt[1:0];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg  <= 1'b0;
            sub_reg       <= '0;
            intervals_reg <= '0;
            left_reg      <= '0;
            run_reg       <= 1'b0;
            home_reg      <= 1'b0;
            hmult_reg     <= 3'd1;
            period_reg    <= '0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            if (take_in)
            begin
                item_vld_reg <= 1'b1;
            end
            else if (fire && res_last)
            begin
                item_vld_reg <= 1'b0;
            end
            sub_reg       <= sub_next;
            intervals_reg <= intervals_next;
            left_reg      <= left_next;
            run_reg       <= run_next;
            home_reg      <= home_next;
            hmult_reg     <= hmult_next;
            period_reg    <= period_next;
            if (fire)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // request payload
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            cmd_reg        <= cmd;
            axis_reg       <= axis;
            value_reg      <= axis_value;
            events_reg     <= step_events;
            smult_reg      <= step_multiplier;
            min_reg        <= min_endstop_hit;
            max_reg        <= max_endstop_hit;
            toward_max_reg <= home_toward_max;
            hmask_reg      <= home_axes;
            us_reg         <= home_step_us;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            step_mask_reg  <= step_all;
            dir_mask_reg   <= dir_all ^ inv_reg;
            moving_reg     <= run_next;
            homing_reg     <= home_next;
            done_reg       <= move_tick && move_last && move_end;
            pos_out_reg    <= pos_sel;
            period_out_reg <= period_next;
            last_reg       <= res_last;
        end
    end

    assign out_valid     = out_vld_reg;
    assign step_mask     = step_mask_reg;
    assign dir_mask      = dir_mask_reg;
    assign moving        = moving_reg;
    assign homing_active = homing_reg;
    assign move_done     = done_reg;
    assign axis_position = pos_out_reg;
    assign timer_period  = period_out_reg;
    assign last          = last_reg;

endmodule

`default_nettype wire

// ===== sv/mads_axis.sv =====
// ----------------------------------------------------------------------------
// mads_axis
// One axis lane: position, error counter, absolute delta and direction,
// with the Bresenham update for a single sub-step.
// ----------------------------------------------------------------------------
`default_nettype none

module mads_axis (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mads_pkg::lane_ctl_t    ctl,
    input  logic [31:0]            value,
    input  logic [30:0]            intervals,
    input  logic [31:0]            err_start,
    input  logic                   min_hit,
    input  logic                   max_hit,
    input  logic                   home_dir,
    output mads_pkg::lane_stat_t   stat
);
    import mads_pkg::*;

    logic [31:0] pos_reg,   pos_next;
    logic [31:0] err_reg,   err_next;
    logic [31:0] delta_reg, delta_next;
    logic        dir_reg,   dir_next;

    logic        hit;
    logic        delta_nz;
    logic [31:0] err_sum;
    logic [31:0] err_sub;
    logic        fits;
    logic [31:0] err_adv;
    logic [31:0] pos_inc;
    logic [31:0] diff;
    logic [31:0] diff_abs;
    logic        step;

    // endstop in the direction of travel
    assign hit      = dir_reg ? max_hit : min_hit;
    assign delta_nz = |delta_reg;

    // error update: add and add-minus-interval side by side
    assign err_sum  = err_reg + delta_reg;
    assign err_sub  = err_reg + delta_reg - {1'b0, intervals};
    assign fits     = ~err_sum[31];
    assign err_adv  = fits ? err_sub : err_sum;

    assign pos_inc  = dir_reg ? (pos_reg + 32'd1) : (pos_reg - 32'd1);
    assign diff     = value - pos_reg;
    assign diff_abs = diff[31] ? (32'd0 - diff) : diff;

    // next state
    always_comb
    begin
        pos_next   = pos_reg;
        err_next   = err_reg;
        delta_next = delta_reg;
        dir_next   = dir_reg;
        step       = 1'b0;
        unique case (ctl.op)
            OP_HOLD:
            begin
            end
            OP_SET_POS:
            begin
                pos_next = value;
            end
            OP_LOAD:
            begin
                delta_next = diff_abs;
                if (diff != 32'd0)
                begin
                    dir_next = ~diff[31];
                end
            end
            OP_START_MOVE:
            begin
                err_next = err_start;
            end
            OP_START_HOME:
            begin
                err_next   = '1;
                delta_next = {31'd0, ctl.home_sel};
                if (ctl.home_sel)
                begin
                    dir_next = home_dir;
                end
            end
            OP_MOVE_STEP:
            begin
                if (delta_nz && !hit)
                begin
                    err_next = err_adv;
                    if (fits)
                    begin
                        step     = 1'b1;
                        pos_next = pos_inc;
                    end
                end
            end
            OP_HOME_STEP:
            begin
                // counter advances even when the switch holds the axis
                if (delta_nz)
                begin
                    err_next = err_adv;
                    if (fits && !hit)
                    begin
                        step     = 1'b1;
                        pos_next = pos_inc;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            err_reg   <= '0;
            delta_reg <= '0;
            dir_reg   <= 1'b1;
        end
        else
        begin
            pos_reg   <= pos_next;
            err_reg   <= err_next;
            delta_reg <= delta_next;
            dir_reg   <= dir_next;
        end
    end

    assign stat.step   = step;
    assign stat.dir_nx = dir_next;
    assign stat.pos_nx = pos_next;

endmodule

`default_nettype wire

// ===== sv/mads_chk.sv =====
// ----------------------------------------------------------------------------
// mads_chk
// Port-level checks for the step generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multi_axis_dda_step_generator_assert.svh"

module mads_chk (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [4:0]  step_mask,
    input wire logic        moving,
    input wire logic        homing_active,
    input wire logic        move_done,
    input wire logic [16:0] timer_period,
    input wire logic        last
);

    // a stalled result holds
    `MADS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(step_mask))

    // the finishing result closes its request and the move
    `MADS_ASSERT_SAME(a_done_last, out_valid && move_done, last && !moving)

    // a step only happens while moving, homing, or on the final move result
    `MADS_ASSERT_SAME(a_step_owner, out_valid && (step_mask != 5'd0), moving || homing_active || move_done)

    // sub-step results follow back to back with the same timer period
    `MADS_ASSERT_NEXT(a_substep_run, out_valid && out_ready && !last, out_valid && $stable(timer_period))

endmodule

bind multi_axis_dda_step_generator mads_chk u_mads_chk (.*);

`default_nettype wire

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the five-axis DDA step generator. Requests are
// driven through the valid/ready port with random gaps and output stalls.
// A scoreboard keeps its own copy of the axis state and predicts every
// sub-step result. Coverage comes from a directed opener, then random moves,
// homing runs and noise under several direction-invert settings.
// ----------------------------------------------------------------------------
module testbench;

    import mads_pkg::*;

    // command codes the block ignores
    localparam logic [2:0] CMD_RSVD_6 = 3'd6;
    localparam logic [2:0] CMD_RSVD_7 = 3'd7;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [2:0]  axis;
        logic [31:0] axis_value;
        logic [30:0] step_events;
        logic [2:0]  step_multiplier;
        logic [2:0]  min_endstop_hit;
        logic [2:0]  max_endstop_hit;
        logic        home_toward_max;
        logic [2:0]  home_axes;
        logic [15:0] home_step_us;
    } req_t;

    typedef struct packed {
        logic [4:0]  step_mask;
        logic [4:0]  dir_mask;
        logic        moving;
        logic        homing_active;
        logic        move_done;
        logic [31:0] axis_position;
        logic [16:0] timer_period;
        logic        last;
    } pulse_t;

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors the axis state and queues the expected results
    // ------------------------------------------------------------------------
    class step_pulse_scoreboard;
        logic [31:0] pos [OUT_AXES];
        logic [31:0] err [OUT_AXES];
        logic [31:0] delta [OUT_AXES];
        logic [4:0]  dir_bits;
        logic [4:0]  dir_invert;
        logic [31:0] interval_count;
        logic [31:0] intervals_left;
        bit          running;
        bit          homing;
        int          home_mult;
        logic [16:0] period;
        pulse_t      expected_pulses[$];
        int          errors;

        function new();
            for (int i = 0; i < OUT_AXES; i++) begin
                pos[i]   = '0;
                err[i]   = '0;
                delta[i] = '0;
            end
            dir_bits       = '1;
            dir_invert     = '0;
            interval_count = '0;
            intervals_left = '0;
            running        = 1'b0;
            homing         = 1'b0;
            home_mult      = 1;
            period         = '0;
            errors         = 0;
        endfunction

        function void set_dir_invert(logic [4:0] v);
            dir_invert = v;
        endfunction

        function int pending();
            return expected_pulses.size();
        endfunction

        // switch in the current direction of travel
        function bit stop_hit(int i, logic [2:0] mins, logic [2:0] maxs);
            logic [2:0] src;
            src = dir_bits[i] ? maxs : mins;
            return src[i];
        endfunction

        // Bresenham accumulate; 1 when the axis steps
        function bit accumulate(int i);
            err[i] = err[i] + delta[i];
            if (!err[i][31]) begin
                err[i] = err[i] - interval_count;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void step_axis(int i);
            if (dir_bits[i])
                pos[i] = pos[i] + 32'd1;
            else
                pos[i] = pos[i] - 32'd1;
        endfunction

        function pulse_t snapshot(logic [4:0] steps, logic [2:0] ax, bit fin);
            pulse_t p;
            p.step_mask     = steps;
            p.dir_mask      = dir_bits ^ dir_invert;
            p.moving        = running;
            p.homing_active = homing;
            p.move_done     = 1'b0;
            p.axis_position = (ax < OUT_AXES) ? pos[ax] : '0;
            p.timer_period  = period;
            p.last          = fin;
            return p;
        endfunction

        // predict the results of one accepted request
        function void note_request(req_t r);
            pulse_t      burst[$];
            logic [31:0] d;
            logic [4:0]  active;
            logic [4:0]  steps;
            int          n;

            case (r.cmd)
                CMD_SET_POS: begin
                    if (r.axis < OUT_AXES)
                        pos[r.axis] = r.axis_value;
                end
                CMD_LOAD_TARGET: begin
                    if (r.axis < OUT_AXES) begin
                        d = r.axis_value - pos[r.axis];
                        if (d != 0) begin
                            if (d[31]) begin
                                d = -d;
                                dir_bits[r.axis] = 1'b0;
                            end else begin
                                dir_bits[r.axis] = 1'b1;
                            end
                        end
                        delta[r.axis] = d;
                    end
                end
                CMD_START_MOVE: begin
                    interval_count = {1'b0, r.step_events};
                    intervals_left = {1'b0, r.step_events};
                    for (int i = 0; i < OUT_AXES; i++)
                        err[i] = -{2'b0, r.step_events[30:1]};
                    running = 1'b1;
                end
                CMD_TICK: begin
                    if (running) begin
                        // move has priority over homing
                        n = (r.step_multiplier == 0) ? 1 :
                            (r.step_multiplier > 4) ? 4 : int'(r.step_multiplier);
                        active = '0;
                        for (int i = 0; i < OUT_AXES; i++) begin
                            if (delta[i] != 0 && !(i < HOMED_AXES &&
                                stop_hit(i, r.min_endstop_hit, r.max_endstop_hit)))
                                active[i] = 1'b1;
                        end
                        for (int s = 0; s < n; s++) begin
                            steps = '0;
                            for (int i = 0; i < OUT_AXES; i++) begin
                                if (active[i]) begin
                                    if (accumulate(i)) begin
                                        step_axis(i);
                                        steps[i] = 1'b1;
                                    end
                                end
                            end
                            burst.push_back(snapshot(steps, r.axis, s == n - 1));
                        end
                        intervals_left = intervals_left - n;
                        if (intervals_left == 0 || intervals_left[31]) begin
                            running = 1'b0;
                            burst[n-1].moving    = 1'b0;
                            burst[n-1].move_done = 1'b1;
                        end
                    end else if (homing) begin
                        // stops after the first sub-step with no step at all
                        for (int s = 0; s < home_mult && homing; s++) begin
                            steps  = '0;
                            homing = 1'b0;
                            for (int i = 0; i < HOMED_AXES; i++) begin
                                if (delta[i] != 0) begin
                                    if (accumulate(i)) begin
                                        if (!stop_hit(i, r.min_endstop_hit,
                                                      r.max_endstop_hit)) begin
                                            homing = 1'b1;
                                            step_axis(i);
                                            steps[i] = 1'b1;
                                        end
                                    end
                                end
                            end
                            burst.push_back(snapshot(steps, r.axis, 1'b0));
                        end
                        burst[burst.size()-1].last = 1'b1;
                    end
                end
                CMD_START_HOME: begin
                    intervals_left = HOME_INTERVALS;
                    interval_count = 32'd1;
                    if (r.home_step_us < HOME_FAST_US) begin
                        home_mult = 4;
                        period    = {2'b0, r.home_step_us[15:1]};
                    end else if (r.home_step_us < HOME_MID_US) begin
                        home_mult = 2;
                        period    = {1'b0, r.home_step_us};
                    end else begin
                        home_mult = 1;
                        period    = {r.home_step_us, 1'b0};
                    end
                    for (int i = 0; i < OUT_AXES; i++) begin
                        err[i]   = '1;
                        delta[i] = '0;
                    end
                    for (int i = 0; i < HOMED_AXES; i++) begin
                        if (r.home_axes[i]) begin
                            dir_bits[i] = r.home_toward_max;
                            delta[i]    = 32'd1;
                        end
                    end
                    homing = 1'b1;
                end
                CMD_ABORT: begin
                    running   = 1'b0;
                    homing    = 1'b0;
                    home_mult = 1;
                    period    = '0;
                end
                default: ;
            endcase

            // every other case gives a single status result
            if (burst.size() == 0)
                burst.push_back(snapshot('0, r.axis, 1'b1));
            foreach (burst[k])
                expected_pulses.push_back(burst[k]);
        endfunction

        function void compare_field(string name, logic [31:0] e, logic [31:0] a);
            if (e !== a) begin
                $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, e, a);
                errors++;
            end
        endfunction

        function void check_pulse(pulse_t got);
            pulse_t e;
            if (expected_pulses.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual %h", $time, got);
                errors++;
                return;
            end
            e = expected_pulses.pop_front();
            compare_field("step_mask",     e.step_mask,     got.step_mask);
            compare_field("dir_mask",      e.dir_mask,      got.dir_mask);
            compare_field("moving",        e.moving,        got.moving);
            compare_field("homing_active", e.homing_active, got.homing_active);
            compare_field("move_done",     e.move_done,     got.move_done);
            compare_field("axis_position", e.axis_position, got.axis_position);
            compare_field("timer_period",  e.timer_period,  got.timer_period);
            compare_field("last",          e.last,          got.last);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT and signals
    // ------------------------------------------------------------------------
    logic               clk;
    logic               rst_n           = 1'b0;
    logic               cfg_valid       = 1'b0;
    logic               cfg_ready;
    logic [4:0]         cfg_data        = '0;
    logic               in_valid        = 1'b0;
    logic               in_ready;
    logic [2:0]         cmd             = '0;
    logic [2:0]         axis            = '0;
    logic signed [31:0] axis_value      = '0;
    logic [30:0]        step_events     = '0;
    logic [2:0]         step_multiplier = '0;
    logic [2:0]         min_endstop_hit = '0;
    logic [2:0]         max_endstop_hit = '0;
    logic               home_toward_max = 1'b0;
    logic [2:0]         home_axes       = '0;
    logic [15:0]        home_step_us    = '0;
    logic               out_valid;
    logic               out_ready       = 1'b0;
    logic [4:0]         step_mask;
    logic [4:0]         dir_mask;
    logic               moving;
    logic               homing_active;
    logic               move_done;
    logic signed [31:0] axis_position;
    logic [16:0]        timer_period;
    logic               last;

    step_pulse_scoreboard sb = new();
    int items_sent = 0;

    multi_axis_dda_step_generator u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .cmd             (cmd),
        .axis            (axis),
        .axis_value      (axis_value),
        .step_events     (step_events),
        .step_multiplier (step_multiplier),
        .min_endstop_hit (min_endstop_hit),
        .max_endstop_hit (max_endstop_hit),
        .home_toward_max (home_toward_max),
        .home_axes       (home_axes),
        .home_step_us    (home_step_us),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .step_mask       (step_mask),
        .dir_mask        (dir_mask),
        .moving          (moving),
        .homing_active   (homing_active),
        .move_done       (move_done),
        .axis_position   (axis_position),
        .timer_period    (timer_period),
        .last            (last)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    initial
    begin
        #1_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // all fields random; callers override what matters
    function automatic req_t random_request(logic [2:0] c);
        req_t r;
        r.cmd             = c;
        r.axis            = 3'($urandom_range(0, 7));
        r.axis_value      = $urandom;
        r.step_events     = 31'($urandom);
        r.step_multiplier = 3'($urandom);
        r.min_endstop_hit = 3'($urandom);
        r.max_endstop_hit = 3'($urandom);
        r.home_toward_max = 1'($urandom);
        r.home_axes       = 3'($urandom);
        r.home_step_us    = 16'($urandom);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Result monitor and output stalls
    // ------------------------------------------------------------------------
    initial
    begin
        pulse_t got;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready) begin
                got.step_mask     = step_mask;
                got.dir_mask      = dir_mask;
                got.moving        = moving;
                got.homing_active = homing_active;
                got.move_done     = move_done;
                got.axis_position = axis_position;
                got.timer_period  = timer_period;
                got.last          = last;
                sb.check_pulse(got);
            end
        end
    end

    initial
    begin
        int hold;
        forever begin
            hold = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) :
                                                 $urandom_range(1, 8);
            out_ready <= 1'b1;
            repeat (hold) @(posedge clk);
            hold = pick_gap();
            if (hold > 0) begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request driver tasks
    // ------------------------------------------------------------------------
    task automatic idle_in(int n);
        if (n > 0) begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_request(req_t r);
        in_valid        <= 1'b1;
        cmd             <= r.cmd;
        axis            <= r.axis;
        axis_value      <= r.axis_value;
        step_events     <= r.step_events;
        step_multiplier <= r.step_multiplier;
        min_endstop_hit <= r.min_endstop_hit;
        max_endstop_hit <= r.max_endstop_hit;
        home_toward_max <= r.home_toward_max;
        home_axes       <= r.home_axes;
        home_step_us    <= r.home_step_us;
        do @(posedge clk); while (!in_ready);
        sb.note_request(r);
        items_sent++;
        idle_in(pick_gap());
    endtask

    // hold off until every predicted result has come back
    task automatic wait_results_done();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cfg(logic [4:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_dir_invert(v);
    endtask

    // directed opener: wraps, limits, special cases
    task automatic run_directed();
        req_t r;
        r = random_request(CMD_TICK);                   // tick while idle
        send_request(r);
        r = random_request(CMD_SET_POS);
        r.axis = 3'd0; r.axis_value = 32'h7FFF_FFFF;
        send_request(r);
        r = random_request(CMD_SET_POS);
        r.axis = 3'd1; r.axis_value = 32'h8000_0000;
        send_request(r);
        r = random_request(CMD_SET_POS);                // axis out of range
        r.axis = 3'd7;
        send_request(r);
        r = random_request(CMD_LOAD_TARGET);            // +1 across the wrap
        r.axis = 3'd0; r.axis_value = 32'h8000_0000;
        send_request(r);
        r = random_request(CMD_LOAD_TARGET);            // -1 across the wrap
        r.axis = 3'd1; r.axis_value = 32'h7FFF_FFFF;
        send_request(r);
        r = random_request(CMD_LOAD_TARGET);            // zero difference
        r.axis = 3'd2; r.axis_value = sb.pos[2];
        send_request(r);
        r = random_request(CMD_LOAD_TARGET);
        r.axis = 3'd5;
        send_request(r);
        r = random_request(CMD_START_MOVE);
        r.step_events = 31'd1;
        send_request(r);
        r = random_request(CMD_TICK);                   // multiplier zero
        r.step_multiplier = 3'd0; r.min_endstop_hit = '0; r.max_endstop_hit = '0;
        send_request(r);
        r = random_request(CMD_START_MOVE);
        r.step_events = '1;
        send_request(r);
        r = random_request(CMD_TICK);                   // multiplier above four
        r.step_multiplier = 3'd7; r.min_endstop_hit = '0; r.max_endstop_hit = '0;
        send_request(r);
        r = random_request(CMD_TICK);
        r.step_multiplier = 3'd3; r.min_endstop_hit = '0; r.max_endstop_hit = '0;
        send_request(r);
        r = random_request(CMD_TICK);                   // every switch hit
        r.step_multiplier = 3'd4; r.min_endstop_hit = '1; r.max_endstop_hit = '1;
        send_request(r);
        r = random_request(CMD_START_HOME);             // homing while moving
        r.home_step_us = 16'd0; r.home_toward_max = 1'b1; r.home_axes = 3'b111;
        send_request(r);
        r = random_request(CMD_TICK);
        r.step_multiplier = 3'd2; r.min_endstop_hit = '0; r.max_endstop_hit = '0;
        send_request(r);
        r = random_request(CMD_ABORT);
        send_request(r);
        r = random_request(CMD_START_HOME);             // slowest, no axes
        r.home_step_us = 16'hFFFF; r.home_axes = 3'b000;
        send_request(r);
        r = random_request(CMD_TICK);
        send_request(r);
        r = random_request(CMD_START_HOME);
        r.home_step_us = 16'd49; r.home_toward_max = 1'b0; r.home_axes = 3'b101;
        send_request(r);
        r = random_request(CMD_TICK);
        r.min_endstop_hit = '0;
        send_request(r);
        r = random_request(CMD_TICK);                   // all homed axes on switch
        r.min_endstop_hit = '1;
        send_request(r);
        r = random_request(CMD_START_HOME);
        r.home_step_us = HOME_FAST_US;
        send_request(r);
        r = random_request(CMD_START_HOME);
        r.home_step_us = HOME_MID_US;
        send_request(r);
        r = random_request(CMD_RSVD_6);
        send_request(r);
        r = random_request(CMD_RSVD_7);
        send_request(r);
        r = random_request(CMD_ABORT);
        send_request(r);
    endtask

    // well-formed move: positions, targets, start, ticks to the end
    task automatic run_move();
        req_t       r;
        logic [4:0] chosen;
        int         d;
        int         span;
        int         ticks;
        chosen = 5'($urandom_range(1, 31));
        span   = 0;
        for (int a = 0; a < OUT_AXES; a++) begin
            if (chosen[a]) begin
                if ($urandom_range(0, 2) != 0) begin
                    r = random_request(CMD_SET_POS);
                    r.axis = 3'(a);
                    case ($urandom_range(0, 3))
                        0: r.axis_value = 32'h7FFF_FFF0 + $urandom_range(0, 15);
                        1: r.axis_value = 32'h8000_0000 + $urandom_range(0, 15);
                        default: r.axis_value = $urandom;
                    endcase
                    send_request(r);
                end
                d = $urandom_range(0, 60) - 30;
                r = random_request(CMD_LOAD_TARGET);
                r.axis = 3'(a);
                r.axis_value = sb.pos[a] + 32'(d);
                send_request(r);
                if (d < 0)
                    d = -d;
                if (d > span)
                    span = d;
            end
        end
        r = random_request(CMD_START_MOVE);
        r.step_events = 31'(span + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : 0));
        send_request(r);
        ticks = 0;
        while (sb.running && ticks < 80) begin
            r = random_request(CMD_TICK);
            if ($urandom_range(0, 4) != 0)
                r.step_multiplier = ($urandom_range(0, 2) == 0) ? 3'd1 :
                                    ($urandom_range(0, 1) == 0) ? 3'd2 : 3'd4;
            if ($urandom_range(0, 9) != 0) begin
                r.min_endstop_hit = '0;
                r.max_endstop_hit = '0;
            end
            send_request(r);
            ticks++;
        end
        if (sb.running) begin
            r = random_request(CMD_ABORT);
            send_request(r);
        end
    endtask

    // well-formed homing run: switches close at random until all are closed
    task automatic run_homing();
        req_t       r;
        logic       toward;
        logic [2:0] hits;
        int         ticks;
        r = random_request(CMD_ABORT);
        send_request(r);
        r = random_request(CMD_START_HOME);
        case ($urandom_range(0, 2))
            0: r.home_step_us = 16'($urandom_range(0, 49));
            1: r.home_step_us = 16'($urandom_range(50, 99));
            default: r.home_step_us = 16'($urandom_range(100, 65535));
        endcase
        toward = r.home_toward_max;
        send_request(r);
        hits  = '0;
        ticks = 0;
        while (sb.homing && ticks < 40) begin
            r = random_request(CMD_TICK);
            if (ticks >= 2)
                hits = hits | 3'($urandom);
            if (ticks >= 8)
                hits = '1;
            if (toward)
                r.max_endstop_hit = hits;
            else
                r.min_endstop_hit = hits;
            send_request(r);
            ticks++;
        end
        if (sb.homing) begin
            r = random_request(CMD_ABORT);
            send_request(r);
        end
    endtask

    task automatic run_random(int budget);
        int start;
        int roll;
        start = items_sent;
        while (items_sent - start < budget) begin
            roll = $urandom_range(0, 99);
            if (roll < 55)
                run_move();
            else if (roll < 75)
                run_homing();
            else
                repeat ($urandom_range(1, 4))
                    send_request(random_request(3'($urandom)));
            if ($urandom_range(0, 19) == 0)
                wait_results_done();
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_cfg(5'h00);
        run_directed();
        for (int p = 1; p <= 4; p++) begin
            wait_results_done();
            case (p)
                1: write_cfg(5'h1F);
                3: write_cfg(5'h00);
                default: write_cfg(5'($urandom));
            endcase
            run_random(30);
        end
        wait_results_done();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/mads_pkg.sv
sv/mads_axis.sv
sv/multi_axis_dda_step_generator.sv
sv/mads_chk.sv
dv/testbench.sv
